// File: design/pcpa_pkg.sv
// Shared types and constants of the per-CPU page allocator.
package pcpa_pkg;

  localparam int PAGE_W = 15;
  localparam int REF_W  = 8;
  localparam int CNT_W  = 32;
  localparam int TOT_W  = 16;

  // command codes
  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_REFGET = 2'd2;
  localparam logic [1:0] CMD_REFCNT = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  localparam logic [REF_W-1:0] REF_MAX = '1;

  // controller to datapath
  typedef struct packed {
    logic latch;       // capture a new transaction
    logic probe_next;  // move the steal probe to the next cpu
    logic take;        // capture the head of the probed list
    logic exec;        // update state and register the result
    logic fail;        // report an empty pool
    logic clear;       // write one zero of the reset sweep
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_alloc;
    logic head_valid;
    logic probe_last;
    logic clear_last;
  } ctl_sts_t;

endpackage

// File: design/pcpa_ram.sv
// Generic single write port RAM with a registered read port.
module pcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/pcpa_ctrl.sv
// Sequencer of the page allocator: clearing sweep, steal probe, execute.
module pcpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pcpa_pkg::ctl_sts_t sts,
  output pcpa_pkg::ctl_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_ISSUE = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;

  logic [2:0] state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!sts.is_alloc) begin
          state_nxt = S_ISSUE;
        end else if (sts.head_valid) begin
          cmd.take = 1'b1;
          state_nxt = S_EXEC;
        end else if (sts.probe_last) begin
          cmd.fail = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.probe_next = 1'b1;
        end
      end
      S_ISSUE: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: design/pcpa_dp.sv
// Datapath of the page allocator: lists, counters, memories, result register.
module pcpa_dp #(
  parameter int CPUS  = 4,
  parameter int PAGES = 32768
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pcpa_pkg::ctl_cmd_t             ctl,
  output pcpa_pkg::ctl_sts_t             sts,
  input  logic [1:0]                     in_command,
  input  logic [1:0]                     in_cpu,
  input  logic [pcpa_pkg::PAGE_W-1:0]    in_page,
  input  logic                           cfg_we,
  input  logic [pcpa_pkg::PAGE_W-1:0]    cfg_wdata,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [pcpa_pkg::PAGE_W-1:0]    out_page_out,
  output logic [pcpa_pkg::REF_W-1:0]     out_ref_count,
  output logic [pcpa_pkg::CNT_W-1:0]     out_alloc_count,
  output logic [pcpa_pkg::CNT_W-1:0]     out_free_count,
  output logic [pcpa_pkg::CNT_W-1:0]     out_steal_count,
  output logic [pcpa_pkg::TOT_W-1:0]     out_total_free
);

  localparam int AW = $clog2(PAGES);
  localparam int LW = AW + 1;  // link entry: end flag on top of the index
  localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int PW = pcpa_pkg::PAGE_W;
  localparam int RW = pcpa_pkg::REF_W;
  localparam int NW = pcpa_pkg::CNT_W;
  localparam int TW = pcpa_pkg::TOT_W;

  // fold the 2-bit cpu field into range by repeated subtraction
  function automatic logic [CW-1:0] cpu_wrap(input logic [1:0] c);
    logic [2:0] v;
    v = {1'b0, c};
    for (int k = 0; k < 3; k++) begin
      if (32'(v) >= CPUS) v = v - 3'(CPUS);
    end
    return CW'(v);
  endfunction

  // transaction and probe registers
  logic [1:0]    cmd_r, cmd_nxt;
  logic [CW-1:0] cpu_r, cpu_nxt;
  logic [PW-1:0] page_r, page_nxt;
  logic [PW-1:0] fup_r, fup_nxt;
  logic [CW-1:0] probe_r, probe_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  logic [CW-1:0] src_r, src_nxt;
  logic [AW-1:0] pg_r, pg_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  // list heads and counters
  logic [AW-1:0] head_r   [CPUS];
  logic [AW-1:0] head_nxt [CPUS];
  logic          hval_r   [CPUS];
  logic          hval_nxt [CPUS];
  logic [NW-1:0] alloc_r  [CPUS];
  logic [NW-1:0] alloc_nxt[CPUS];
  logic [NW-1:0] free_r   [CPUS];
  logic [NW-1:0] free_nxt [CPUS];
  logic [NW-1:0] steal_r  [CPUS];
  logic [NW-1:0] steal_nxt[CPUS];
  logic [TW-1:0] total_r, total_nxt;

  // result register
  logic          ov_r, ov_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic [PW-1:0] opg_r, opg_nxt;
  logic [RW-1:0] oref_r, oref_nxt;
  logic [NW-1:0] oal_r, oal_nxt;
  logic [NW-1:0] ofr_r, ofr_nxt;
  logic [NW-1:0] ost2_r, ost2_nxt;
  logic [TW-1:0] otot_r, otot_nxt;

  // memory ports
  logic          refs_we;
  logic [AW-1:0] refs_wa;
  logic [RW-1:0] refs_wd;
  logic [RW-1:0] refs_q;
  logic          link_we;
  logic [LW-1:0] link_wd;
  logic [LW-1:0] link_q;
  logic [AW-1:0] page_a;
  logic          inr;

  assign page_a = AW'(page_r);
  assign inr    = (32'(page_r) < PAGES);

  pcpa_ram #(.WIDTH(RW), .DEPTH(PAGES)) u_refs (
    .clk  (clk),
    .we   (refs_we),
    .waddr(refs_wa),
    .wdata(refs_wd),
    .raddr(page_a),
    .rdata(refs_q)
  );

  pcpa_ram #(.WIDTH(LW), .DEPTH(PAGES)) u_link (
    .clk  (clk),
    .we   (link_we),
    .waddr(page_a),
    .wdata(link_wd),
    .raddr(head_r[probe_r]),
    .rdata(link_q)
  );

  // status to the controller
  always_comb begin
    sts.is_alloc   = (cmd_r == pcpa_pkg::CMD_ALLOC);
    sts.head_valid = hval_r[probe_r];
    sts.probe_last = (steps_r == CW'(CPUS - 1));
    sts.clear_last = (clr_r == AW'(PAGES - 1));
  end

  // next state
  always_comb begin
    cmd_nxt   = cmd_r;
    cpu_nxt   = cpu_r;
    page_nxt  = page_r;
    fup_nxt   = fup_r;
    probe_nxt = probe_r;
    steps_nxt = steps_r;
    src_nxt   = src_r;
    pg_nxt    = pg_r;
    clr_nxt   = clr_r;
    head_nxt  = head_r;
    hval_nxt  = hval_r;
    alloc_nxt = alloc_r;
    free_nxt  = free_r;
    steal_nxt = steal_r;
    total_nxt = total_r;
    ov_nxt    = 1'b0;
    ost_nxt   = ost_r;
    opg_nxt   = opg_r;
    oref_nxt  = oref_r;
    oal_nxt   = oal_r;
    ofr_nxt   = ofr_r;
    ost2_nxt  = ost2_r;
    otot_nxt  = otot_r;
    refs_we   = 1'b0;
    refs_wa   = page_a;
    refs_wd   = '0;
    link_we   = 1'b0;
    link_wd   = {!hval_r[cpu_r], head_r[cpu_r]};

    if (cfg_we) fup_nxt = cfg_wdata;

    // reset sweep of the count memory
    if (ctl.clear) begin
      refs_we = 1'b1;
      refs_wa = clr_r;
      clr_nxt = clr_r + 1'b1;
    end

    if (ctl.latch) begin
      cmd_nxt   = in_command;
      cpu_nxt   = cpu_wrap(in_cpu);
      page_nxt  = in_page;
      probe_nxt = cpu_wrap(in_cpu);
      steps_nxt = '0;
    end

    if (ctl.probe_next) begin
      probe_nxt = (probe_r == CW'(CPUS - 1)) ? '0 : probe_r + 1'b1;
      steps_nxt = steps_r + 1'b1;
    end

    if (ctl.take) begin
      pg_nxt  = head_r[probe_r];
      src_nxt = probe_r;
    end

    if (ctl.fail) begin
      ov_nxt   = 1'b1;
      ost_nxt  = pcpa_pkg::ST_EMPTY;
      opg_nxt  = '0;
      oref_nxt = '0;
    end

    if (ctl.exec) begin
      ov_nxt   = 1'b1;
      ost_nxt  = pcpa_pkg::ST_OK;
      opg_nxt  = '0;
      oref_nxt = '0;
      unique case (cmd_r)
        pcpa_pkg::CMD_ALLOC: begin
          // pop the probed list, follow its link
          refs_we = 1'b1;
          refs_wa = pg_r;
          refs_wd = RW'(1);
          if (link_q[AW]) hval_nxt[src_r] = 1'b0;
          else            head_nxt[src_r] = link_q[AW-1:0];
          alloc_nxt[cpu_r] = alloc_r[cpu_r] + 1'b1;
          if (src_r != cpu_r) steal_nxt[cpu_r] = steal_r[cpu_r] + 1'b1;
          total_nxt = total_r - 1'b1;
          opg_nxt   = PW'(pg_r);
          oref_nxt  = RW'(1);
        end
        pcpa_pkg::CMD_FREE: begin
          if (!inr || page_r < fup_r) begin
            ost_nxt  = pcpa_pkg::ST_BAD;
            oref_nxt = inr ? refs_q : '0;
          end else if (refs_q > RW'(1)) begin
            refs_we  = 1'b1;
            refs_wd  = refs_q - 1'b1;
            oref_nxt = refs_q - 1'b1;
          end else begin
            // last reference: push onto the requester's list
            refs_we = 1'b1;
            link_we = 1'b1;
            head_nxt[cpu_r] = page_a;
            hval_nxt[cpu_r] = 1'b1;
            free_nxt[cpu_r] = free_r[cpu_r] + 1'b1;
            total_nxt = total_r + 1'b1;
          end
        end
        pcpa_pkg::CMD_REFGET: begin
          if (!inr) begin
            ost_nxt = pcpa_pkg::ST_BAD;
          end else if (refs_q == pcpa_pkg::REF_MAX) begin
            ost_nxt  = pcpa_pkg::ST_SAT;
            oref_nxt = pcpa_pkg::REF_MAX;
          end else begin
            refs_we  = 1'b1;
            refs_wd  = refs_q + 1'b1;
            oref_nxt = refs_q + 1'b1;
          end
        end
        pcpa_pkg::CMD_REFCNT: begin
          oref_nxt = inr ? refs_q : '0;
        end
        default: begin
          ost_nxt = pcpa_pkg::ST_OK;
        end
      endcase
    end

    // counters seen by the requester after the transaction
    if (ctl.exec || ctl.fail) begin
      oal_nxt  = alloc_nxt[cpu_r];
      ofr_nxt  = free_nxt[cpu_r];
      ost2_nxt = steal_nxt[cpu_r];
      otot_nxt = total_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fup_r   <= '0;
      clr_r   <= '0;
      total_r <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < CPUS; i++) begin
        hval_r[i]  <= 1'b0;
        alloc_r[i] <= '0;
        free_r[i]  <= '0;
        steal_r[i] <= '0;
      end
    end else begin
      fup_r   <= fup_nxt;
      clr_r   <= clr_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
      hval_r  <= hval_nxt;
      alloc_r <= alloc_nxt;
      free_r  <= free_nxt;
      steal_r <= steal_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    cpu_r   <= cpu_nxt;
    page_r  <= page_nxt;
    probe_r <= probe_nxt;
    steps_r <= steps_nxt;
    src_r   <= src_nxt;
    pg_r    <= pg_nxt;
    head_r  <= head_nxt;
    ost_r   <= ost_nxt;
    opg_r   <= opg_nxt;
    oref_r  <= oref_nxt;
    oal_r   <= oal_nxt;
    ofr_r   <= ofr_nxt;
    ost2_r  <= ost2_nxt;
    otot_r  <= otot_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_page_out    = opg_r;
  assign out_ref_count   = oref_r;
  assign out_alloc_count = oal_r;
  assign out_free_count  = ofr_r;
  assign out_steal_count = ost2_r;
  assign out_total_free  = otot_r;

endmodule

// File: design/per_cpu_page_allocator_refcount_unit.sv
// Top level of the per-CPU page allocator with reference counts.
// After reset the unit zeroes the reference-count memory, one page per cycle,
// with busy high; configuration writes are taken meanwhile. A transaction is
// taken when start is high and busy low. Reference commands pass through the
// probe, issue and execute states before the result strobe; an allocation
// probes the lists from the requester's own onwards, one list head per cycle,
// past at most CPUS-1 empty lists before a non-empty one, then executes; an
// allocation that finds every list empty reports an empty pool. Each
// transaction does at most one read and one write of the count and link
// memories, whose read port is registered. out_valid marks the result for one
// cycle and the receiver cannot stall; busy drops as the result is registered,
// so the next transaction may start during the strobe.
module per_cpu_page_allocator_refcount_unit #(
  parameter int CPUS  = 4,
  parameter int PAGES = 32768
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_command,
  input  logic [1:0]                  in_cpu,
  input  logic [pcpa_pkg::PAGE_W-1:0] in_page,
  input  logic                        cfg_we,
  input  logic [pcpa_pkg::PAGE_W-1:0] cfg_wdata,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [pcpa_pkg::PAGE_W-1:0] out_page_out,
  output logic [pcpa_pkg::REF_W-1:0]  out_ref_count,
  output logic [pcpa_pkg::CNT_W-1:0]  out_alloc_count,
  output logic [pcpa_pkg::CNT_W-1:0]  out_free_count,
  output logic [pcpa_pkg::CNT_W-1:0]  out_steal_count,
  output logic [pcpa_pkg::TOT_W-1:0]  out_total_free
);

  pcpa_pkg::ctl_cmd_t ctl;
  pcpa_pkg::ctl_sts_t sts;

  pcpa_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .sts  (sts),
    .cmd  (ctl)
  );

  pcpa_dp #(.CPUS(CPUS), .PAGES(PAGES)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .in_command     (in_command),
    .in_cpu         (in_cpu),
    .in_page        (in_page),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_page_out   (out_page_out),
    .out_ref_count  (out_ref_count),
    .out_alloc_count(out_alloc_count),
    .out_free_count (out_free_count),
    .out_steal_count(out_steal_count),
    .out_total_free (out_total_free)
  );

endmodule
